// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Each macro expands to one labeled concurrent assertion on a clock with an
// active-low reset that disables it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |-> (CONS)) \
        else $error("%m: property violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
    LABEL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |=> (CONS)) \
        else $error("%m: property violated");

`endif

// ===== sv/tta_pkg.sv =====
// Package for the tensor transpose address generator.
// Holds the fixed widths, register indexes and the sequencer control type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tta_pkg;

    localparam int NDIM       = 4;
    localparam int DIM_W      = 2;
    localparam int SEQ_STEPS  = 2 * NDIM;
    localparam int STEP_W     = 3;
    localparam int OFF_W      = 32;
    localparam int DATA_W     = 64;
    localparam int ORDER_W    = 3;
    localparam int PERM_W     = 8;
    localparam int EDGE_CFG_W = 9;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam int NUM_REGS   = 7;

    localparam logic [REG_IDX_W-1:0] REG_ORDER       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIRECTION   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PERMUTATION = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_EDGE0       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EDGE3       = 3'd6;

    localparam logic [PERM_W-1:0] PERM_RESET = 8'd228;

    typedef struct packed {
        logic               start;
        logic [ORDER_W-1:0] order;
        logic [PERM_W-1:0]  perm;
    } seq_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/tta_stride_seq.sv =====
// Stride sequencer: derives the per-dimension offset increments of the permuted layout.
// Uses one shared multiplier over eight steps after reset and after each start.
// Depends on tta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tta_stride_seq #(
    parameter int EDGE_W = 9
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  tta_pkg::seq_ctrl_t                            ctrl,
    input  logic [tta_pkg::NDIM-1:0][EDGE_W-1:0]          eff_edge,
    output logic [tta_pkg::NDIM-1:0][tta_pkg::OFF_W-1:0]  delta,
    output logic                                          busy
);
    import tta_pkg::*;

    logic [STEP_W-1:0]            step_reg;
    logic                         busy_reg;
    logic [OFF_W-1:0]             acc_reg;
    logic [NDIM-1:0][OFF_W-1:0]   ns_reg;
    logic [NDIM-1:0][OFF_W-1:0]   delta_reg;

    logic                         phase_b;
    logic [DIM_W-1:0]             idx;
    logic [DIM_W-1:0]             dim;
    logic                         active;
    logic [OFF_W-1:0]             mul_a;
    logic [EDGE_W-1:0]            mul_b;
    logic [OFF_W+EDGE_W-1:0]      prod;

    // The first half places the permuted strides, the second half turns them
    // into the offset change for a carry into each dimension.
    assign phase_b = (step_reg >= STEP_W'(NDIM));
    assign idx     = step_reg[DIM_W-1:0];
    assign dim     = ctrl.perm[DIM_W*idx +: DIM_W];
    assign active  = (ORDER_W'(idx) < ctrl.order);
    assign mul_a   = phase_b ? ns_reg[idx] : acc_reg;
    assign mul_b   = phase_b ? (eff_edge[idx] - EDGE_W'(1)) : eff_edge[dim];
    assign prod    = (OFF_W+EDGE_W)'(mul_a) * (OFF_W+EDGE_W)'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b1;
            acc_reg  <= OFF_W'(1);
            ns_reg   <= '0;
        end
        else if (ctrl.start)
        begin
            step_reg <= '0;
            busy_reg <= 1'b1;
            acc_reg  <= OFF_W'(1);
            ns_reg   <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SEQ_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
            if (!phase_b)
            begin
                if (active)
                begin
                    ns_reg[dim] <= acc_reg;
                    acc_reg     <= prod[OFF_W-1:0];
                end
                if (idx == DIM_W'(NDIM - 1))
                begin
                    acc_reg <= '0;
                end
            end
            else if (active)
            begin
                acc_reg <= acc_reg + prod[OFF_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && phase_b && active)
        begin
            delta_reg[idx] <= ns_reg[idx] - acc_reg;
        end
    end

    assign delta = delta_reg;
    assign busy  = busy_reg;

endmodule

`default_nettype wire

// ===== sv/tensor_transpose_address_generator_unit.sv =====
// Top level of the tensor transpose address generator.
// Depends on tta_pkg and tta_stride_seq.
//
// Usage:
// Tensor elements arrive on the input channel (in_valid, in_stall, element)
// in the walk order of the old layout, dimension 0 innermost. Each accepted
// transaction yields one result transaction on the output channel
// (out_valid, out_stall, element_out, read_offset, write_offset, last),
// registered in the output buffer. One transaction is taken per cycle
// while in_stall is low. A two-entry output buffer lets the block take a
// new transaction while a result waits; in_stall rises when both entries
// are full or the stride sequencer is busy. Registers must be written over
// the APB port only while the block is idle; the block does not enforce
// this. A write to a valid register restarts the walk at offset zero and
// starts the stride sequencer, which holds in_stall high until every step of
// its shared multiplier is done. The same derivation runs after reset, with
// order 1, direction 1, permutation 228 and every edge length 1. The last
// flag marks the final element of a pass; the next element starts a new pass.
`timescale 1ns / 1ps
`default_nettype none

module tensor_transpose_address_generator_unit #(
    parameter int MAX_ORDER = 4,
    parameter int EDGE_BITS = 8,
    parameter int ELEM_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tta_pkg::DATA_W-1:0]       element,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tta_pkg::DATA_W-1:0]       element_out,
    output logic [tta_pkg::OFF_W-1:0]        read_offset,
    output logic [tta_pkg::OFF_W-1:0]        write_offset,
    output logic                             last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tta_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tta_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tta_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import tta_pkg::*;

    localparam int LIMIT    = (MAX_ORDER < NDIM) ? MAX_ORDER : NDIM;
    localparam int CNT_W    = (EDGE_BITS < EDGE_CFG_W) ? EDGE_BITS : EDGE_CFG_W;
    localparam int EE_W     = CNT_W + 1;
    localparam int MAX_EDGE = 1 << EDGE_BITS;

    typedef struct packed {
        logic [ELEM_BITS-1:0] elem;
        logic [OFF_W-1:0]     rd;
        logic [OFF_W-1:0]     wr;
        logic                 fin;
    } result_t;

    logic [ORDER_W-1:0]         order_reg;
    logic                       dir_reg;
    logic [PERM_W-1:0]          perm_reg;
    logic [EDGE_CFG_W-1:0]      edge_reg [NDIM];

    logic [NDIM-1:0][CNT_W-1:0] cnt_reg;
    logic [NDIM-1:0][CNT_W-1:0] cnt_next;
    logic [OFF_W-1:0]           old_off_reg;
    logic [OFF_W-1:0]           new_off_reg;
    logic [OFF_W-1:0]           old_off_next;
    logic [OFF_W-1:0]           new_off_next;
    logic [OFF_W-1:0]           sel_delta;
    logic                       pass_end;

    logic [ORDER_W-1:0]         eff_order;
    logic [NDIM-1:0][EE_W-1:0]  eff_edge;
    logic [NDIM-1:0][OFF_W-1:0] delta;
    logic                       seq_busy;
    seq_ctrl_t                  seq_ctrl;

    logic                       cfg_wr;
    logic                       cfg_hit;
    logic [REG_IDX_W-1:0]       cfg_idx;
    logic [DIM_W-1:0]           edge_sel;

    logic                       accept;
    logic                       take;
    logic                       out_valid_reg;
    logic                       skid_valid_reg;
    result_t                    main_reg;
    result_t                    skid_reg;
    result_t                    res_new;

    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[APB_ADDR_W-1:2];
    assign cfg_hit  = cfg_wr && (cfg_idx < REG_IDX_W'(NUM_REGS));
    assign edge_sel = DIM_W'(cfg_idx - REG_EDGE0);
    assign pready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_W'(1);
            dir_reg   <= 1'b1;
            perm_reg  <= PERM_RESET;
            for (int d = 0; d < NDIM; d++)
            begin
                edge_reg[d] <= EDGE_CFG_W'(1);
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ORDER:       order_reg <= pwdata[ORDER_W-1:0];
                REG_DIRECTION:   dir_reg   <= pwdata[0];
                REG_PERMUTATION: perm_reg  <= pwdata[PERM_W-1:0];
                default:
                begin
                    if (cfg_idx inside {[REG_EDGE0:REG_EDGE3]})
                    begin
                        edge_reg[edge_sel] <= pwdata[EDGE_CFG_W-1:0];
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ORDER:       prdata = APB_DATA_W'(order_reg);
            REG_DIRECTION:   prdata = APB_DATA_W'(dir_reg);
            REG_PERMUTATION: prdata = APB_DATA_W'(perm_reg);
            default:
            begin
                if (cfg_idx inside {[REG_EDGE0:REG_EDGE3]})
                begin
                    prdata = APB_DATA_W'(edge_reg[edge_sel]);
                end
                else
                begin
                    prdata = '0;
                end
            end
        endcase
    end

    // Out-of-range order and edge values are clamped here; dimensions beyond
    // the order get extent one.
    always_comb
    begin
        if (order_reg == '0)
        begin
            eff_order = ORDER_W'(1);
        end
        else if (int'(order_reg) > LIMIT)
        begin
            eff_order = ORDER_W'(LIMIT);
        end
        else
        begin
            eff_order = order_reg;
        end
        for (int d = 0; d < NDIM; d++)
        begin
            if (d >= int'(eff_order) || edge_reg[d] == '0)
            begin
                eff_edge[d] = EE_W'(1);
            end
            else if (int'(edge_reg[d]) > MAX_EDGE)
            begin
                eff_edge[d] = EE_W'(MAX_EDGE);
            end
            else
            begin
                eff_edge[d] = EE_W'(edge_reg[d]);
            end
        end
    end

    assign seq_ctrl.start = cfg_hit;
    assign seq_ctrl.order = eff_order;
    assign seq_ctrl.perm  = perm_reg;

    tta_stride_seq #(
        .EDGE_W (EE_W)
    ) u_stride_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (seq_ctrl),
        .eff_edge (eff_edge),
        .delta    (delta),
        .busy     (seq_busy)
    );

    // Odometer step: the lowest dimension not at its end advances and all
    // lower ones wrap. The old offset simply counts; the new one adds the
    // precomputed change for the advancing dimension.
    always_comb
    begin
        logic carry;
        carry     = 1'b1;
        sel_delta = '0;
        for (int d = 0; d < NDIM; d++)
        begin
            cnt_next[d] = cnt_reg[d];
            if (carry)
            begin
                if (EE_W'(cnt_reg[d]) == eff_edge[d] - EE_W'(1))
                begin
                    cnt_next[d] = '0;
                end
                else
                begin
                    cnt_next[d] = cnt_reg[d] + CNT_W'(1);
                    sel_delta   = delta[d];
                    carry       = 1'b0;
                end
            end
        end
        pass_end     = carry;
        old_off_next = pass_end ? '0 : old_off_reg + OFF_W'(1);
        new_off_next = pass_end ? '0 : new_off_reg + sel_delta;
    end

    assign res_new.elem = element[ELEM_BITS-1:0];
    assign res_new.rd   = dir_reg ? old_off_reg : new_off_reg;
    assign res_new.wr   = dir_reg ? new_off_reg : old_off_reg;
    assign res_new.fin  = pass_end;

    assign in_stall = seq_busy || skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign take     = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            old_off_reg <= '0;
            new_off_reg <= '0;
        end
        else if (cfg_hit)
        begin
            cnt_reg     <= '0;
            old_off_reg <= '0;
            new_off_reg <= '0;
        end
        else if (accept)
        begin
            cnt_reg     <= cnt_next;
            old_off_reg <= old_off_next;
            new_off_reg <= new_off_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            main_reg <= skid_valid_reg ? skid_reg : res_new;
        end
        if (accept && out_valid_reg && !take)
        begin
            skid_reg <= res_new;
        end
    end

    assign out_valid    = out_valid_reg;
    assign element_out  = DATA_W'(main_reg.elem);
    assign read_offset  = main_reg.rd;
    assign write_offset = main_reg.wr;
    assign last         = main_reg.fin;

endmodule

`default_nettype wire

// ===== sv/tta_checker.sv =====
// Port-level checker for the tensor transpose address generator, with its bind.
// Depends on tta_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tta_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_stall,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [tta_pkg::DATA_W-1:0]       element_out,
    input wire logic [tta_pkg::OFF_W-1:0]        read_offset,
    input wire logic [tta_pkg::OFF_W-1:0]        write_offset,
    input wire logic                             last,
    input wire logic                             psel,
    input wire logic                             penable,
    input wire logic                             pwrite,
    input wire logic [tta_pkg::APB_ADDR_W-1:0]   paddr
);
    import tta_pkg::*;

    logic reg_write;

    assign reg_write = psel && penable && pwrite
                       && (paddr[APB_ADDR_W-1:2] < REG_IDX_W'(NUM_REGS));

    // A stalled result transaction keeps its valid and its payload.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(element_out) && $stable(read_offset) && $stable(write_offset) && $stable(last))

    // Every accepted transaction leaves a result on the output channel.
    `ASSERT_NEXT(a_accept_result, clk, rst_n, in_valid && !in_stall, out_valid)

    // A register write holds off input while the strides are rederived.
    `ASSERT_NEXT(a_cfg_stall, clk, rst_n, reg_write, in_stall)

endmodule

bind tensor_transpose_address_generator_unit tta_checker u_tta_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .element_out  (element_out),
    .read_offset  (read_offset),
    .write_offset (write_offset),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr)
);

`default_nettype wire
